/* hw/rtl/scl_pkg.sv */
// ----------------------------------------------------------------------------
// scl_pkg: speed command line parser package
// Character codes, line sizing, parse phases and the line result record
// shared by the parser modules.
// ----------------------------------------------------------------------------
package scl_pkg;

  // Line store sizing: a line holds up to LINE_CAPACITY-1 characters
  localparam int LINE_CAPACITY = 32;
  localparam int LEN_W         = $clog2(LINE_CAPACITY);

  localparam int BYTE_W  = 8;
  localparam int MAG_W   = 15;
  localparam int SPEED_W = 16;

  localparam logic [LEN_W-1:0] LINE_LAST      = LEN_W'(LINE_CAPACITY - 1);
  localparam logic [LEN_W-1:0] MIN_OK_LENGTH  = LEN_W'(4);
  localparam logic [LEN_W-1:0] POS_SECOND     = LEN_W'(1);
  localparam logic [LEN_W-1:0] POS_THIRD      = LEN_W'(2);

  localparam logic [MAG_W-1:0] MAG_MAX           = 15'd32767;
  localparam logic [MAG_W-1:0] SPEED_LIMIT_RESET = 15'd1000;

  // Character codes
  localparam logic [BYTE_W-1:0] CHAR_AT    = 8'h40;
  localparam logic [BYTE_W-1:0] CHAR_V     = 8'h76;
  localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0d;
  localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0a;
  localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CHAR_VT    = 8'h0b;
  localparam logic [BYTE_W-1:0] CHAR_FF    = 8'h0c;
  localparam logic [BYTE_W-1:0] CHAR_PLUS  = 8'h2b;
  localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2d;
  localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;

  typedef enum logic [1:0] {
    PH_SKIP   = 2'd0,
    PH_DIGITS = 2'd1,
    PH_DONE   = 2'd2
  } phase_t;

  // What the line logic reports for one byte
  typedef struct packed {
    logic             eol;       // byte ended the line: one result
    logic             ok;        // line matched the command prefix
    logic             negative;
    logic [MAG_W-1:0] magnitude;
  } line_result_t;

  function automatic logic is_eol(input logic [BYTE_W-1:0] c);
    return (c == CHAR_CR) || (c == CHAR_LF);
  endfunction

endpackage

/* hw/rtl/speed_command_line_parser.sv */
// ----------------------------------------------------------------------------
// speed_command_line_parser: '@v <int>' speed command parser
// A CR/LF byte is held in the input register, and its line result is then
// registered in the output register.
// Throughput: one byte per cycle; a CR/LF byte waits in the input register only
// while the output register holds a result not yet taken.
// Reset (rst, synchronous): line cleared, no transaction pending, speed_limit=1000.
// ----------------------------------------------------------------------------
module speed_command_line_parser (
  input  logic                        clk,
  input  logic                        rst,
  // received bytes
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [scl_pkg::BYTE_W-1:0]  rx_byte,
  // results
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        status,
  output logic [scl_pkg::SPEED_W-1:0] speed,
  // speed_limit register
  input  logic                        cfg_we,
  input  logic [scl_pkg::MAG_W-1:0]   cfg_wdata
);
  import scl_pkg::*;

  logic [MAG_W-1:0]   speed_limit;

  // input register
  logic               byte_valid;
  logic [BYTE_W-1:0]  byte_q;

  line_result_t       line_res;
  logic               out_free;
  logic               proceed;
  logic               in_accept;

  logic [MAG_W-1:0]   mag_clamped;
  logic [SPEED_W-1:0] speed_next;

  // Only a line end needs the output slot; other bytes always move on.
  assign out_free  = !out_valid || out_ready;
  assign proceed   = byte_valid && (!line_res.eol || out_free);
  assign in_ready  = !byte_valid || proceed;
  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_limit <= SPEED_LIMIT_RESET;
    end else if (cfg_we) begin
      speed_limit <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (in_accept) begin
      byte_valid <= 1'b1;
    end else if (proceed) begin
      byte_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      byte_q <= rx_byte;
    end
  end

  scl_line u_line (
    .clk    (clk),
    .rst    (rst),
    .step   (proceed),
    .ch     (byte_q),
    .result (line_res)
  );

  // Symmetric clamp: |speed| = min(magnitude, limit), sign reapplied after.
  always_comb begin
    if (!line_res.ok) begin
      mag_clamped = '0;
    end else if (line_res.magnitude > speed_limit) begin
      mag_clamped = speed_limit;
    end else begin
      mag_clamped = line_res.magnitude;
    end
    speed_next = line_res.negative ? (SPEED_W'(0) - {1'b0, mag_clamped})
                                   : {1'b0, mag_clamped};
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proceed && line_res.eol) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proceed && line_res.eol) begin
      status <= !line_res.ok;
      speed  <= speed_next;
    end
  end

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> speed == '0)
    else $error("invalid-format transaction with non-zero speed");

  a_within_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && !status && !$past(cfg_we) |->
      $signed(speed) <= $signed({1'b0, speed_limit}) &&
      $signed(speed) >= -$signed({1'b0, speed_limit}))
    else $error("speed outside the configured limit");

  a_stall_reason: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> byte_valid && line_res.eol && out_valid && !out_ready)
    else $error("input stalled without a blocked line end");

  a_result_from_eol: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(proceed && line_res.eol))
    else $error("result without a line end");

endmodule

/* hw/rtl/scl_line.sv */
// ----------------------------------------------------------------------------
// scl_line: line tracker
// Holds the running state of the current line (length, prefix flags and the
// atoi-style number parse) and reports the line outcome on CR or LF.
// ----------------------------------------------------------------------------
module scl_line (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       step,
  input  logic [scl_pkg::BYTE_W-1:0] ch,
  output scl_pkg::line_result_t      result
);
  import scl_pkg::*;

  logic [LEN_W-1:0] line_length, line_length_next;
  logic             first_is_at, first_is_at_next;
  logic             second_is_v, second_is_v_next;
  logic             third_is_space, third_is_space_next;
  phase_t           number_phase, number_phase_next;
  logic             value_negative, value_negative_next;
  logic [MAG_W-1:0] value_magnitude, value_magnitude_next;

  logic             is_ws, is_sign, is_digit;
  logic [MAG_W+3:0] mag_wide;

  assign is_ws    = (ch == CHAR_SPACE) || (ch == CHAR_TAB) || (ch == CHAR_VT) ||
                    (ch == CHAR_FF);
  assign is_sign  = (ch == CHAR_PLUS) || (ch == CHAR_MINUS);
  assign is_digit = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);

  // mag*10 + digit, at most 327679
  assign mag_wide = ({4'b0, value_magnitude} << 3) + ({4'b0, value_magnitude} << 1) +
                    {{MAG_W{1'b0}}, ch[3:0]};

  assign result.eol       = is_eol(ch);
  assign result.ok        = (line_length >= MIN_OK_LENGTH) && first_is_at &&
                            second_is_v && third_is_space;
  assign result.negative  = value_negative;
  assign result.magnitude = value_magnitude;

  always_comb begin
    line_length_next     = line_length;
    first_is_at_next     = first_is_at;
    second_is_v_next     = second_is_v;
    third_is_space_next  = third_is_space;
    number_phase_next    = number_phase;
    value_negative_next  = value_negative;
    value_magnitude_next = value_magnitude;

    if (ch == CHAR_AT || is_eol(ch) || line_length >= LINE_LAST) begin
      // restart, end of line, or overflow: all clear the line
      line_length_next     = '0;
      first_is_at_next     = 1'b0;
      second_is_v_next     = 1'b0;
      third_is_space_next  = 1'b0;
      number_phase_next    = PH_SKIP;
      value_negative_next  = 1'b0;
      value_magnitude_next = '0;
      if (ch == CHAR_AT) begin
        first_is_at_next = 1'b1;
        line_length_next = LEN_W'(1);
      end
    end else begin
      line_length_next = line_length + LEN_W'(1);
      if (line_length == '0) begin
        first_is_at_next = 1'b0;
      end else if (line_length == POS_SECOND) begin
        second_is_v_next = (ch == CHAR_V);
      end else if (line_length == POS_THIRD) begin
        third_is_space_next = (ch == CHAR_SPACE);
      end else if (number_phase == PH_SKIP && is_ws) begin
        // leading whitespace
      end else if (number_phase == PH_SKIP && is_sign) begin
        value_negative_next = (ch == CHAR_MINUS);
        number_phase_next   = PH_DIGITS;
      end else if (number_phase == PH_DONE) begin
        // number already ended
      end else if (!is_digit) begin
        number_phase_next = PH_DONE;
      end else begin
        number_phase_next    = PH_DIGITS;
        value_magnitude_next = (mag_wide > {4'b0, MAG_MAX}) ? MAG_MAX
                                                           : mag_wide[MAG_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length     <= '0;
      first_is_at     <= 1'b0;
      second_is_v     <= 1'b0;
      third_is_space  <= 1'b0;
      number_phase    <= PH_SKIP;
      value_negative  <= 1'b0;
      value_magnitude <= '0;
    end else if (step) begin
      line_length     <= line_length_next;
      first_is_at     <= first_is_at_next;
      second_is_v     <= second_is_v_next;
      third_is_space  <= third_is_space_next;
      number_phase    <= number_phase_next;
      value_negative  <= value_negative_next;
      value_magnitude <= value_magnitude_next;
    end
  end

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    line_length <= LINE_LAST)
    else $error("line length beyond capacity");

  a_at_restart: assert property (@(posedge clk) disable iff (rst)
    step && ch == CHAR_AT |=> line_length == LEN_W'(1) && first_is_at)
    else $error("'@' did not restart the line");

  a_empty_line: assert property (@(posedge clk) disable iff (rst)
    line_length == '0 |-> !first_is_at && !second_is_v && !third_is_space &&
                          value_magnitude == '0)
    else $error("empty line carries stale state");

endmodule
